/* hw/rtl/axis_angle_vector_rotation_macros.svh */
// Assertion macros shared by the axis-angle vector rotation RTL.
`ifndef AXIS_ANGLE_VECTOR_ROTATION_MACROS_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define AAVR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define AAVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/aavr_pkg.sv */
// Shared constants, types and the arctangent table function for the rotation block.
`timescale 1ns / 1ps
package aavr_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int ANGLE_WIDTH = 32;
  localparam int TRIG_STEPS  = 24;

  localparam int FRAC    = 30;
  localparam int MAG_W   = 30;
  localparam int SHIFT_W = $clog2(DATA_WIDTH);
  localparam int WIDE_W  = DATA_WIDTH + MAG_W;
  localparam int RES_W   = ANGLE_WIDTH - 1;
  localparam int CORD_W  = 34;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic signed [31:0] PI_Q29 = 32'sh6487ED51;
  localparam logic [CORD_W-1:0] PI4_Q30 = CORD_W'((PI_Q60 + (64'd1 << 31)) >> 32);
  localparam logic [CORD_W-1:0] GAIN_Q30 = CORD_W'(32'h26DD3B6A);

  typedef struct packed {
    logic [2:0][DATA_WIDTH-1:0] vec;
    logic [2:0][MAG_W-1:0]      mag;
    logic [2:0]                 neg;
    logic                       zero;
    logic [1:0]                 quad;
    logic [RES_W-1:0]           res;
  } front_word_t;

  typedef struct packed {
    logic room;
    logic nempty;
  } qstat_t;

  // Arctangent of 2^-i in Q30, summed as an alternating series in Q62.
  function automatic logic [CORD_W-1:0] atan_q30(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] den;
    int unsigned d;
    acc = 64'd0;
    if (i == 0) begin
      return PI4_Q30;
    end
    for (int k = 0; k < 32; k++) begin
      d = 2 * k + 1;
      if (i * d <= 62) begin
        num = 64'd1 << (62 - i * d);
        den = 64'(d);
        rem = 64'd0;
        quo = 64'd0;
        for (int b = 63; b >= 0; b--) begin
          rem = {rem[62:0], num[b]};
          if (rem >= den) begin
            rem = rem - den;
            quo[b] = 1'b1;
          end
        end
        if (k % 2 == 1) begin
          acc = acc - quo;
        end else begin
          acc = acc + quo;
        end
      end
    end
    return CORD_W'((acc + (64'd1 << 31)) >> 32);
  endfunction

endpackage

/* hw/rtl/axis_angle_vector_rotation.sv */
// Rotates a vector about an axis of any length by a binary angle; one word in, one word out,
// one word per clock sustained while the output buffer is not full. An accepted word loads the
// front register, moves into the four-word queue, then through 70 back-end stages (squares,
// sum, a 32-stage square root that also runs the CORDIC steps, a 31-stage divider for the unit
// axis, five matrix stages) and into the two-word output buffer. The whole back end holds while
// the output buffer is full; the queue then fills and full rises.
`timescale 1ns / 1ps
`include "axis_angle_vector_rotation_macros.svh"
module axis_angle_vector_rotation (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_vec_x,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_vec_y,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_vec_z,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_axis_x,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_axis_y,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_axis_z,
  input  logic [aavr_pkg::ANGLE_WIDTH-1:0]       in_turn_angle,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [aavr_pkg::DATA_WIDTH-1:0] out_rot_x,
  output logic signed [aavr_pkg::DATA_WIDTH-1:0] out_rot_y,
  output logic signed [aavr_pkg::DATA_WIDTH-1:0] out_rot_z,
  output logic                                   out_axis_zero
);

  aavr_pkg::front_word_t push_word;
  aavr_pkg::front_word_t head_word;
  aavr_pkg::qstat_t q_stat;
  logic q_push;
  logic q_pop;

  aavr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .in_axis_x     (in_axis_x),
    .in_axis_y     (in_axis_y),
    .in_axis_z     (in_axis_z),
    .in_turn_angle (in_turn_angle),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_word        (push_word)
  );

  aavr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .head_word (head_word),
    .q_stat    (q_stat)
  );

  aavr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_word        (head_word),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_rot_x     (out_rot_x),
    .out_rot_y     (out_rot_y),
    .out_rot_z     (out_rot_z),
    .out_axis_zero (out_axis_zero)
  );

  `AAVR_ASSERT_SAME(a_push_room, q_push, q_stat.room, "Word pushed into a full queue.")
  `AAVR_ASSERT_SAME(a_pop_nempty, q_pop, q_stat.nempty, "Word popped from an empty queue.")
  `AAVR_ASSERT_NEXT(a_push_fills, q_push, q_stat.nempty, "Queue empty after a push.")
  `AAVR_ASSERT_SAME(a_zero_axis, !out_empty && out_axis_zero,
    out_rot_x == 0 && out_rot_y == 0 && out_rot_z == 0, "Zero axis with nonzero result.")

endmodule

/* hw/rtl/aavr_front.sv */
// Front end: takes input words, finds a zero axis, normalizes the axis and folds the angle.
`timescale 1ns / 1ps
module aavr_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_vec_x,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_vec_y,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_vec_z,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_axis_x,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_axis_y,
  input  logic signed [aavr_pkg::DATA_WIDTH-1:0] in_axis_z,
  input  logic [aavr_pkg::ANGLE_WIDTH-1:0]     in_turn_angle,
  input  aavr_pkg::qstat_t                     q_stat,
  output logic                                 q_push,
  output aavr_pkg::front_word_t                q_word
);

  localparam int DW = aavr_pkg::DATA_WIDTH;
  localparam int AW = aavr_pkg::ANGLE_WIDTH;

  aavr_pkg::front_word_t f_word_r, f_word_nxt;
  logic f_valid_r, f_valid_nxt;
  logic accept;

  logic [2:0][DW-1:0] axis_in;
  logic [2:0][DW-1:0] mag_abs;
  logic [DW-1:0] mx;
  logic [aavr_pkg::SHIFT_W-1:0] msb;
  logic [aavr_pkg::WIDE_W-1:0] wide;
  logic [AW-1:0] turn;

  assign axis_in = {in_axis_z, in_axis_y, in_axis_x};
  assign in_full = f_valid_r && !q_stat.room;
  assign q_push  = f_valid_r && q_stat.room;
  assign accept  = in_push && !in_full;
  assign q_word  = f_word_r;

  always_comb begin
    mx = '0;
    msb = '0;
    f_word_nxt.vec = {in_vec_z, in_vec_y, in_vec_x};
    for (int j = 0; j < 3; j++) begin
      f_word_nxt.neg[j] = axis_in[j][DW-1];
      mag_abs[j] = axis_in[j][DW-1] ? (~axis_in[j] + DW'(1)) : axis_in[j];
      if (mag_abs[j] > mx) begin
        mx = mag_abs[j];
      end
    end
    for (int b = 0; b < DW; b++) begin
      if (mx[b]) begin
        msb = aavr_pkg::SHIFT_W'(b);
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (int'(msb) >= aavr_pkg::MAG_W - 1) begin
        wide = aavr_pkg::WIDE_W'(mag_abs[j]) >> (int'(msb) - (aavr_pkg::MAG_W - 1));
      end else begin
        wide = aavr_pkg::WIDE_W'(mag_abs[j]) << ((aavr_pkg::MAG_W - 1) - int'(msb));
      end
      f_word_nxt.mag[j] = wide[aavr_pkg::MAG_W-1:0];
    end
    f_word_nxt.zero = (mx == '0);
    turn = in_turn_angle + AW'(1 << (AW - 3));
    f_word_nxt.quad = turn[AW-1:AW-2];
    f_word_nxt.res = aavr_pkg::RES_W'(turn[AW-3:0]) - aavr_pkg::RES_W'(1 << (AW - 3));
  end

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_word_r <= f_word_nxt;
    end
  end

endmodule

/* hw/rtl/aavr_queue.sv */
// Four-word queue that decouples the front end from the arithmetic back end.
`timescale 1ns / 1ps
module aavr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  aavr_pkg::front_word_t push_word,
  input  logic                  pop,
  output aavr_pkg::front_word_t head_word,
  output aavr_pkg::qstat_t      q_stat
);

  localparam int PW = aavr_pkg::QPTR_W;
  localparam int CW = aavr_pkg::QCNT_W;

  aavr_pkg::front_word_t mem_r [aavr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign head_word     = mem_r[rptr_r];
  assign q_stat.room   = (cnt_r != CW'(aavr_pkg::QUEUE_DEPTH));
  assign q_stat.nempty = (cnt_r != '0);

  always_comb begin
    wptr_nxt = push ? wptr_r + PW'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + PW'(1) : rptr_r;
    cnt_nxt  = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_word;
    end
  end

endmodule

/* hw/rtl/aavr_back.sv */
// Back end: square root, CORDIC, unit-axis division, rotation matrix and output buffer.
`timescale 1ns / 1ps
module aavr_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  aavr_pkg::front_word_t                  q_word,
  input  aavr_pkg::qstat_t                       q_stat,
  output logic                                   q_pop,
  input  logic                                   out_pop,
  output logic                                   out_empty,
  output logic signed [aavr_pkg::DATA_WIDTH-1:0] out_rot_x,
  output logic signed [aavr_pkg::DATA_WIDTH-1:0] out_rot_y,
  output logic signed [aavr_pkg::DATA_WIDTH-1:0] out_rot_z,
  output logic                                   out_axis_zero
);

  localparam int DW     = aavr_pkg::DATA_WIDTH;
  localparam int AW     = aavr_pkg::ANGLE_WIDTH;
  localparam int MW     = aavr_pkg::MAG_W;
  localparam int CRW    = aavr_pkg::CORD_W;
  localparam int FR     = aavr_pkg::FRAC;
  localparam int SQ_W   = 2 * MW;
  localparam int RT_W   = 64;
  localparam int RP_W   = aavr_pkg::RES_W + 32;
  localparam int N_W    = MW + 1;
  localparam int REM_W  = 2 * MW + 2;
  localparam int QUO_W  = MW + 1;
  localparam int U_W    = 32;
  localparam int W_W    = 33;
  localparam int PP_W   = 64;
  localparam int A_W    = 34;
  localparam int PW_W   = A_W + W_W;
  localparam int M_W    = 35;
  localparam int PR_W   = DW + M_W;
  localparam int ROW_W  = PR_W + 2;
  localparam int ROOT_STAGES = 32;
  localparam int DIV_STAGES  = QUO_W;

  localparam logic signed [RP_W-1:0] RP_HALF = RP_W'(1) <<< (AW - 3);
  localparam logic signed [CRW-1:0]  ONE_C   = CRW'(1) <<< FR;
  localparam logic signed [PP_W-1:0] HALF_PP = PP_W'(1) <<< (FR - 1);
  localparam logic signed [PW_W-1:0] HALF_PW = PW_W'(1) <<< (FR - 1);
  localparam logic signed [ROW_W-1:0] HALF_ROW = ROW_W'(1) <<< (FR - 1);
  localparam logic signed [ROW_W-1:0] LIM_HI = ROW_W'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic signed [ROW_W-1:0] LIM_LO = -LIM_HI - ROW_W'(1);

  typedef struct packed {
    logic [2:0][DW-1:0]   vec;
    logic [2:0][MW-1:0]   mag;
    logic [2:0]           neg;
    logic                 zero;
    logic [1:0]           quad;
    logic [2:0][SQ_W-1:0] sq;
    logic [RP_W-1:0]      rp;
  } pre_t;

  typedef struct packed {
    logic [2:0][DW-1:0] vec;
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
    logic [1:0]         quad;
    logic [RT_W-1:0]    rx;
    logic [CRW-1:0]     z;
  } sum_t;

  typedef struct packed {
    logic [2:0][DW-1:0] vec;
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
    logic [1:0]         quad;
    logic [RT_W-1:0]    rx;
    logic [RT_W-1:0]    rr;
    logic [CRW-1:0]     cx;
    logic [CRW-1:0]     cy;
    logic [CRW-1:0]     cz;
  } root_t;

  typedef struct packed {
    logic [2:0][DW-1:0]    vec;
    logic [2:0]            neg;
    logic                  zero;
    logic [1:0]            quad;
    logic [CRW-1:0]        cx;
    logic [CRW-1:0]        cy;
    logic [N_W-1:0]        n;
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [2:0][DW-1:0]  vec;
    logic                zero;
    logic [2:0][U_W-1:0] u;
    logic [U_W-1:0]      c;
    logic [U_W-1:0]      s;
    logic [W_W-1:0]      w;
  } m0_t;

  typedef struct packed {
    logic [2:0][DW-1:0]   vec;
    logic                 zero;
    logic [5:0][PP_W-1:0] pp;
    logic [2:0][PP_W-1:0] ss;
    logic [U_W-1:0]       c;
    logic [W_W-1:0]       w;
  } m1_t;

  typedef struct packed {
    logic [2:0][DW-1:0]   vec;
    logic                 zero;
    logic [5:0][PW_W-1:0] pw;
    logic [2:0][A_W-1:0]  sr;
    logic [U_W-1:0]       c;
  } m2_t;

  typedef struct packed {
    logic [2:0][DW-1:0]  vec;
    logic                zero;
    logic [8:0][M_W-1:0] m;
  } m3_t;

  typedef struct packed {
    logic                 zero;
    logic [8:0][PR_W-1:0] prod;
  } m4_t;

  typedef struct packed {
    logic [2:0][DW-1:0] rot;
    logic               zero;
  } out_word_t;

  logic adv;

  pre_t pre_r, pre_nxt;
  sum_t sum_r, sum_nxt;
  root_t root_seed;
  root_t root_r [ROOT_STAGES];
  root_t root_nxt [ROOT_STAGES];
  div_t div_seed;
  div_t div_r [DIV_STAGES];
  div_t div_nxt [DIV_STAGES];
  m0_t m0_r, m0_nxt;
  m1_t m1_r, m1_nxt;
  m2_t m2_r, m2_nxt;
  m3_t m3_r, m3_nxt;
  m4_t m4_r, m4_nxt;
  logic pre_v_r, sum_v_r, m0_v_r, m1_v_r, m2_v_r, m3_v_r, m4_v_r;
  logic [ROOT_STAGES-1:0] root_v_r;
  logic [DIV_STAGES-1:0] div_v_r;

  out_word_t ob_r [2];
  out_word_t ob_nxt;
  logic ob_wptr_r, ob_wptr_nxt, ob_rptr_r, ob_rptr_nxt;
  logic [1:0] ob_cnt_r, ob_cnt_nxt;
  logic ob_wr, ob_rd;

  assign adv   = (ob_cnt_r != 2'd2);
  assign q_pop = adv && q_stat.nempty;

  // Squares of the normalized axis and the angle product.
  always_comb begin
    pre_nxt.vec  = q_word.vec;
    pre_nxt.mag  = q_word.mag;
    pre_nxt.neg  = q_word.neg;
    pre_nxt.zero = q_word.zero;
    pre_nxt.quad = q_word.quad;
    for (int j = 0; j < 3; j++) begin
      pre_nxt.sq[j] = SQ_W'(q_word.mag[j]) * SQ_W'(q_word.mag[j]);
    end
    pre_nxt.rp = $signed(q_word.res) * aavr_pkg::PI_Q29;
  end

  always_comb begin
    logic signed [RP_W-1:0] zt;
    sum_nxt.vec  = pre_r.vec;
    sum_nxt.mag  = pre_r.mag;
    sum_nxt.neg  = pre_r.neg;
    sum_nxt.zero = pre_r.zero;
    sum_nxt.quad = pre_r.quad;
    sum_nxt.rx   = RT_W'(pre_r.sq[0]) + RT_W'(pre_r.sq[1]) + RT_W'(pre_r.sq[2]);
    zt = ($signed(pre_r.rp) + RP_HALF) >>> (AW - 2);
    sum_nxt.z = zt[CRW-1:0];
  end

  always_comb begin
    root_seed.vec  = sum_r.vec;
    root_seed.mag  = sum_r.mag;
    root_seed.neg  = sum_r.neg;
    root_seed.zero = sum_r.zero;
    root_seed.quad = sum_r.quad;
    root_seed.rx   = sum_r.rx;
    root_seed.rr   = '0;
    root_seed.cx   = aavr_pkg::GAIN_Q30;
    root_seed.cy   = '0;
    root_seed.cz   = sum_r.z;
  end

  // Each stage retires one root digit and, while steps remain, one CORDIC rotation.
  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
    localparam logic [RT_W-1:0] BIT = RT_W'(1) << (62 - 2 * k);
    localparam logic signed [CRW-1:0] ANG = aavr_pkg::atan_q30(k);
    root_t src;
    if (k == 0) begin : g_first
      assign src = root_seed;
    end else begin : g_next
      assign src = root_r[k-1];
    end
    always_comb begin
      logic [RT_W-1:0] trial;
      logic signed [CRW-1:0] xs, ys, zs, dx, dy;
      root_nxt[k] = src;
      trial = src.rr + BIT;
      if (src.rx >= trial) begin
        root_nxt[k].rx = src.rx - trial;
        root_nxt[k].rr = (src.rr >> 1) + BIT;
      end else begin
        root_nxt[k].rr = src.rr >> 1;
      end
      xs = src.cx;
      ys = src.cy;
      zs = src.cz;
      dx = ys >>> k;
      dy = xs >>> k;
      if (k < aavr_pkg::TRIG_STEPS) begin
        if (zs >= 0) begin
          root_nxt[k].cx = xs - dx;
          root_nxt[k].cy = ys + dy;
          root_nxt[k].cz = zs - ANG;
        end else begin
          root_nxt[k].cx = xs + dx;
          root_nxt[k].cy = ys - dy;
          root_nxt[k].cz = zs + ANG;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[k] <= root_nxt[k];
      end
    end
  end

  always_comb begin
    logic [N_W-1:0] nv;
    nv = root_r[ROOT_STAGES-1].rr[N_W-1:0];
    div_seed.vec  = root_r[ROOT_STAGES-1].vec;
    div_seed.neg  = root_r[ROOT_STAGES-1].neg;
    div_seed.zero = root_r[ROOT_STAGES-1].zero;
    div_seed.quad = root_r[ROOT_STAGES-1].quad;
    div_seed.cx   = root_r[ROOT_STAGES-1].cx;
    div_seed.cy   = root_r[ROOT_STAGES-1].cy;
    div_seed.n    = nv;
    div_seed.quo  = '0;
    for (int j = 0; j < 3; j++) begin
      div_seed.rem[j] = (REM_W'(root_r[ROOT_STAGES-1].mag[j]) << FR) + REM_W'(nv >> 1);
    end
  end

  // Restoring division, one quotient bit per stage for all three components.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int B = QUO_W - 1 - k;
    div_t src;
    if (k == 0) begin : g_first
      assign src = div_seed;
    end else begin : g_next
      assign src = div_r[k-1];
    end
    always_comb begin
      logic [REM_W-1:0] dv;
      div_nxt[k] = src;
      dv = REM_W'(src.n) << B;
      for (int j = 0; j < 3; j++) begin
        if (src.rem[j] >= dv) begin
          div_nxt[k].rem[j] = src.rem[j] - dv;
          div_nxt[k].quo[j][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // Signed unit axis, quadrant mapping and clamped cosine and sine.
  always_comb begin
    logic signed [CRW-1:0] xs, ys, cc, sc;
    logic signed [U_W-1:0] qv;
    logic signed [W_W-1:0] cw;
    m0_nxt.vec  = div_r[DIV_STAGES-1].vec;
    m0_nxt.zero = div_r[DIV_STAGES-1].zero;
    for (int j = 0; j < 3; j++) begin
      qv = U_W'(div_r[DIV_STAGES-1].quo[j]);
      m0_nxt.u[j] = div_r[DIV_STAGES-1].neg[j] ? -qv : qv;
    end
    xs = div_r[DIV_STAGES-1].cx;
    ys = div_r[DIV_STAGES-1].cy;
    case (div_r[DIV_STAGES-1].quad)
      2'd0: begin
        cc = xs;
        sc = ys;
      end
      2'd1: begin
        cc = -ys;
        sc = xs;
      end
      2'd2: begin
        cc = -xs;
        sc = -ys;
      end
      default: begin
        cc = ys;
        sc = -xs;
      end
    endcase
    if (cc > ONE_C) cc = ONE_C;
    if (cc < -ONE_C) cc = -ONE_C;
    if (sc > ONE_C) sc = ONE_C;
    if (sc < -ONE_C) sc = -ONE_C;
    m0_nxt.c = cc[U_W-1:0];
    m0_nxt.s = sc[U_W-1:0];
    cw = W_W'(ONE_C) - W_W'(cc);
    m0_nxt.w = cw;
  end

  always_comb begin
    logic signed [U_W-1:0] ua, ub, sv;
    m1_nxt.vec  = m0_r.vec;
    m1_nxt.zero = m0_r.zero;
    m1_nxt.c    = m0_r.c;
    m1_nxt.w    = m0_r.w;
    sv = m0_r.s;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin ua = m0_r.u[0]; ub = m0_r.u[0]; end
        1: begin ua = m0_r.u[1]; ub = m0_r.u[1]; end
        2: begin ua = m0_r.u[2]; ub = m0_r.u[2]; end
        3: begin ua = m0_r.u[0]; ub = m0_r.u[1]; end
        4: begin ua = m0_r.u[0]; ub = m0_r.u[2]; end
        default: begin ua = m0_r.u[1]; ub = m0_r.u[2]; end
      endcase
      m1_nxt.pp[p] = ua * ub;
    end
    for (int j = 0; j < 3; j++) begin
      ua = m0_r.u[j];
      m1_nxt.ss[j] = ua * sv;
    end
  end

  always_comb begin
    logic signed [PP_W-1:0] pr, rr;
    logic signed [A_W-1:0] av;
    logic signed [W_W-1:0] wv;
    m2_nxt.vec  = m1_r.vec;
    m2_nxt.zero = m1_r.zero;
    m2_nxt.c    = m1_r.c;
    wv = m1_r.w;
    for (int p = 0; p < 6; p++) begin
      pr = m1_r.pp[p];
      rr = (pr + HALF_PP) >>> FR;
      av = rr[A_W-1:0];
      m2_nxt.pw[p] = av * wv;
    end
    for (int j = 0; j < 3; j++) begin
      pr = m1_r.ss[j];
      rr = (pr + HALF_PP) >>> FR;
      m2_nxt.sr[j] = rr[A_W-1:0];
    end
  end

  always_comb begin
    logic signed [PW_W-1:0] pw, pr;
    logic signed [M_W-1:0] pt [6];
    logic signed [M_W-1:0] sx, sy, sz, cm;
    logic signed [U_W-1:0] cu;
    logic signed [A_W-1:0] sa;
    m3_nxt.vec  = m2_r.vec;
    m3_nxt.zero = m2_r.zero;
    for (int p = 0; p < 6; p++) begin
      pw = m2_r.pw[p];
      pr = (pw + HALF_PW) >>> FR;
      pt[p] = pr[M_W-1:0];
    end
    sa = m2_r.sr[0];
    sx = M_W'(sa);
    sa = m2_r.sr[1];
    sy = M_W'(sa);
    sa = m2_r.sr[2];
    sz = M_W'(sa);
    cu = m2_r.c;
    cm = M_W'(cu);
    m3_nxt.m[0] = pt[0] + cm;
    m3_nxt.m[1] = pt[3] - sz;
    m3_nxt.m[2] = pt[4] + sy;
    m3_nxt.m[3] = pt[3] + sz;
    m3_nxt.m[4] = pt[1] + cm;
    m3_nxt.m[5] = pt[5] - sx;
    m3_nxt.m[6] = pt[4] - sy;
    m3_nxt.m[7] = pt[5] + sx;
    m3_nxt.m[8] = pt[2] + cm;
  end

  always_comb begin
    logic signed [DW-1:0] vv;
    logic signed [M_W-1:0] mv;
    m4_nxt.zero = m3_r.zero;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        vv = m3_r.vec[j];
        mv = m3_r.m[3*i+j];
        m4_nxt.prod[3*i+j] = vv * mv;
      end
    end
  end

  // Row sums, rounding and saturation into the output buffer.
  always_comb begin
    logic signed [ROW_W-1:0] acc;
    logic signed [PR_W-1:0] pv;
    ob_nxt.zero = m4_r.zero;
    for (int i = 0; i < 3; i++) begin
      acc = HALF_ROW;
      for (int j = 0; j < 3; j++) begin
        pv = m4_r.prod[3*i+j];
        acc = acc + ROW_W'(pv);
      end
      acc = acc >>> FR;
      if (acc > LIM_HI) acc = LIM_HI;
      if (acc < LIM_LO) acc = LIM_LO;
      ob_nxt.rot[i] = m4_r.zero ? '0 : acc[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r <= pre_nxt;
      sum_r <= sum_nxt;
      m0_r  <= m0_nxt;
      m1_r  <= m1_nxt;
      m2_r  <= m2_nxt;
      m3_r  <= m3_nxt;
      m4_r  <= m4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r  <= 1'b0;
      sum_v_r  <= 1'b0;
      root_v_r <= '0;
      div_v_r  <= '0;
      m0_v_r   <= 1'b0;
      m1_v_r   <= 1'b0;
      m2_v_r   <= 1'b0;
      m3_v_r   <= 1'b0;
      m4_v_r   <= 1'b0;
    end else if (adv) begin
      pre_v_r  <= q_pop;
      sum_v_r  <= pre_v_r;
      root_v_r <= {root_v_r[ROOT_STAGES-2:0], sum_v_r};
      div_v_r  <= {div_v_r[DIV_STAGES-2:0], root_v_r[ROOT_STAGES-1]};
      m0_v_r   <= div_v_r[DIV_STAGES-1];
      m1_v_r   <= m0_v_r;
      m2_v_r   <= m1_v_r;
      m3_v_r   <= m2_v_r;
      m4_v_r   <= m3_v_r;
    end
  end

  assign ob_wr = adv && m4_v_r;
  assign ob_rd = out_pop && (ob_cnt_r != 2'd0);

  always_comb begin
    ob_wptr_nxt = ob_wr ? !ob_wptr_r : ob_wptr_r;
    ob_rptr_nxt = ob_rd ? !ob_rptr_r : ob_rptr_r;
    ob_cnt_nxt  = ob_cnt_r + 2'(ob_wr) - 2'(ob_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wptr_r <= 1'b0;
      ob_rptr_r <= 1'b0;
      ob_cnt_r  <= 2'd0;
    end else begin
      ob_wptr_r <= ob_wptr_nxt;
      ob_rptr_r <= ob_rptr_nxt;
      ob_cnt_r  <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_wr) begin
      ob_r[ob_wptr_r] <= ob_nxt;
    end
  end

  assign out_empty     = (ob_cnt_r == 2'd0);
  assign out_rot_x     = ob_r[ob_rptr_r].rot[0];
  assign out_rot_y     = ob_r[ob_rptr_r].rot[1];
  assign out_rot_z     = ob_r[ob_rptr_r].rot[2];
  assign out_axis_zero = ob_r[ob_rptr_r].zero;

endmodule
